// ===== hw/rtl/kvte_pkg.sv =====
// Shared types and codes for the key-value table with expiry.
package kvte_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS  = 32;
  localparam int ACT_BITS   = 3;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_SET    = 3'd0,
    ACT_GET    = 3'd1,
    ACT_DEL    = 3'd2,
    ACT_EXPIRE = 3'd3,
    ACT_TICK   = 3'd4,
    ACT_SWEEP  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK
  } state_t;

  // Token and lookup status handed from cell to cell.
  typedef struct packed {
    logic                  tok;
    logic                  hit;
    logic                  found;
    logic                  free_seen;
    logic [VALUE_BITS-1:0] value;
  } link_t;

  // Request controls broadcast to every cell.
  typedef struct packed {
    action_t act;
    logic    ttl_pos;
    logic    sweep;
    logic    commit;
    logic    clear;
  } ctrl_t;

endpackage

// ===== hw/rtl/kvte_cell.sv =====
// One table slot: holds an entry and serves the lookup token as it passes.
module kvte_cell #(
  parameter int KEY_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kvte_pkg::ctrl_t                     ctrl,
  input  logic [KEY_BITS-1:0]                 req_key,
  input  logic [kvte_pkg::VALUE_BITS-1:0]     req_value,
  input  logic [kvte_pkg::TIME_BITS-1:0]      now,
  input  logic [kvte_pkg::TIME_BITS-1:0]      exp_target,
  input  kvte_pkg::link_t                     link_in,
  output kvte_pkg::link_t                     link_out
);
  import kvte_pkg::*;

  logic                  valid_r, valid_nxt;
  logic                  cand_r, cand_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  has_exp_r, has_exp_nxt;
  logic [TIME_BITS-1:0]  exp_r, exp_nxt;
  link_t                 link_r, link_nxt;
  logic                  match;
  logic                  expired;

  assign match   = link_in.tok && valid_r && (key_r == req_key);
  assign expired = has_exp_r && (now > exp_r);

  always_comb begin
    valid_nxt   = valid_r;
    cand_nxt    = cand_r;
    key_nxt     = key_r;
    value_nxt   = value_r;
    has_exp_nxt = has_exp_r;
    exp_nxt     = exp_r;
    link_nxt    = link_in;

    if (ctrl.clear) begin
      cand_nxt = 1'b0;
    end

    if (link_in.tok) begin
      case (ctrl.act)
        ACT_SET: begin
          if (match) begin
            value_nxt      = req_value;
            has_exp_nxt    = 1'b0;
            link_nxt.hit   = 1'b1;
            link_nxt.found = 1'b1;
          end else if (!valid_r && !link_in.free_seen) begin
            cand_nxt           = 1'b1;
            link_nxt.free_seen = 1'b1;
          end
        end
        ACT_GET: begin
          if (match) begin
            link_nxt.hit = 1'b1;
            if (expired) begin
              valid_nxt = 1'b0;
            end else begin
              link_nxt.found = 1'b1;
              link_nxt.value = value_r;
            end
          end
        end
        ACT_DEL: begin
          if (match) begin
            valid_nxt      = 1'b0;
            link_nxt.hit   = 1'b1;
            link_nxt.found = 1'b1;
          end
        end
        ACT_EXPIRE: begin
          if (match) begin
            link_nxt.hit   = 1'b1;
            link_nxt.found = 1'b1;
            if (ctrl.ttl_pos) begin
              has_exp_nxt = 1'b1;
              exp_nxt     = exp_target;
            end else begin
              valid_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (ctrl.sweep && valid_r && expired) begin
      valid_nxt = 1'b0;
    end

    if (ctrl.commit && cand_r) begin
      valid_nxt   = 1'b1;
      cand_nxt    = 1'b0;
      key_nxt     = req_key;
      value_nxt   = req_value;
      has_exp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      cand_r     <= 1'b0;
      link_r.tok <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      cand_r     <= cand_nxt;
      link_r.tok <= link_nxt.tok;
    end
    link_r.hit       <= link_nxt.hit;
    link_r.found     <= link_nxt.found;
    link_r.free_seen <= link_nxt.free_seen;
    link_r.value     <= link_nxt.value;
    key_r            <= key_nxt;
    value_r          <= value_nxt;
    has_exp_r        <= has_exp_nxt;
    exp_r            <= exp_nxt;
  end

  assign link_out = link_r;

endmodule

// ===== hw/rtl/key_value_table_with_expiry.sv =====
// Top level: request capture, sequencer, time base and the row of slot cells.
// Set, get, delete and expire: the lookup token visits one cell per clock along
// the row of ENTRIES cells on its way to out_strobe.
// Tick, sweep and unused codes skip the row; sweep checks all cells at once.
// A new start is taken in the cycle out_strobe is shown; one item at a time.
// Synchronous reset empties the table and zeroes the clock; no clearing pass.
module key_value_table_with_expiry #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [kvte_pkg::ACT_BITS-1:0]       in_action,
  input  logic [63:0]                         in_key,
  input  logic signed [kvte_pkg::VALUE_BITS-1:0] in_value,
  input  logic signed [kvte_pkg::TIME_BITS-1:0]  in_ttl_seconds,
  output logic                                out_strobe,
  output logic                                out_found,
  output logic                                out_full_res,
  output logic signed [kvte_pkg::VALUE_BITS-1:0] out_value_res
);
  import kvte_pkg::*;

  state_t                state_r, state_nxt;
  action_t               act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [TIME_BITS-1:0]  ttl_r;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  found_r, found_nxt;
  logic                  full_r, full_nxt;
  logic [VALUE_BITS-1:0] vres_r, vres_nxt;
  logic                  accept;
  logic                  chain_act;
  logic                  launch;
  logic [TIME_BITS:0]    exp_sum;
  logic [TIME_BITS-1:0]  exp_target;
  ctrl_t                 ctrl;
  link_t                 links [ENTRIES+1];
  link_t                 last;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign exp_sum    = {1'b0, now_r} + {1'b0, ttl_r};
  assign exp_target = exp_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : exp_sum[TIME_BITS-1:0];

  always_comb begin
    unique case (act_r) inside
      ACT_SET, ACT_GET, ACT_DEL, ACT_EXPIRE: chain_act = 1'b1;
      default:                               chain_act = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_nxt = chain_act ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        if (last.tok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    launch       = 1'b0;
    ctrl.act     = act_r;
    ctrl.ttl_pos = (ttl_r != '0) && !ttl_r[TIME_BITS-1];
    ctrl.sweep   = 1'b0;
    ctrl.commit  = 1'b0;
    ctrl.clear   = 1'b0;
    now_nxt      = now_r;
    strobe_nxt   = 1'b0;
    found_nxt    = found_r;
    full_nxt     = full_r;
    vres_nxt     = vres_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_LAUNCH: begin
        if (chain_act) begin
          launch     = 1'b1;
          ctrl.clear = 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          found_nxt  = 1'b0;
          full_nxt   = 1'b0;
          vres_nxt   = '0;
          if (act_r == ACT_TICK && now_r != {TIME_BITS{1'b1}}) begin
            now_nxt = now_r + 1'b1;
          end
          if (act_r == ACT_SWEEP) begin
            ctrl.sweep = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (last.tok) begin
          strobe_nxt = 1'b1;
          found_nxt  = last.found;
          full_nxt   = 1'b0;
          vres_nxt   = last.value;
          if (act_r == ACT_SET && !last.hit) begin
            if (last.free_seen) begin
              ctrl.commit = 1'b1;
              found_nxt   = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      strobe_r <= strobe_nxt;
    end
    found_r <= found_nxt;
    full_r  <= full_nxt;
    vres_r  <= vres_nxt;
    if (accept) begin
      act_r   <= action_t'(in_action);
      key_r   <= in_key[KEY_BITS-1:0];
      value_r <= in_value;
      ttl_r   <= in_ttl_seconds;
    end
  end

  assign links[0].tok       = launch;
  assign links[0].hit       = 1'b0;
  assign links[0].found     = 1'b0;
  assign links[0].free_seen = 1'b0;
  assign links[0].value     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvte_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .req_key   (key_r),
      .req_value (value_r),
      .now       (now_r),
      .exp_target(exp_target),
      .link_in   (links[i]),
      .link_out  (links[i+1])
    );
  end

  assign last = links[ENTRIES];

  assign out_strobe    = strobe_r;
  assign out_found     = found_r;
  assign out_full_res  = full_r;
  assign out_value_res = vres_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == S_IDLE))
    else $error("result shown while busy");

  a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_found && out_full_res))
    else $error("found and full both set");

  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_value_res != '0) |-> out_found)
    else $error("value returned without a hit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transfer taken but block not busy");

  a_commit_set: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> (act_r == ACT_SET && !last.hit && last.tok))
    else $error("commit outside a set miss");

endmodule
